// ----- sv/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and codes for the button click classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  localparam int TimeW    = 32;
  localparam int CfgIdxW  = 2;
  localparam int InDataW  = 40;
  localparam int OutDataW = 8;

  typedef logic [TimeW-1:0] time_ms_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE_TIME       = 2'd0,
    REG_LONG_CLICK_TIME     = 2'd1,
    REG_DOUBLE_CLICK_WINDOW = 2'd2,
    REG_ACTIVE_LOW          = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PHASE_RELEASED = 2'd0,
    PHASE_PRESSED  = 2'd1,
    PHASE_LONGED   = 2'd2
  } click_phase_t;

  typedef struct packed {
    time_ms_t debounce_time;
    time_ms_t long_click_time;
    time_ms_t double_click_window;
    logic     active_low;
  } cfg_t;

  typedef struct packed {
    logic double_event;
    logic long_event;
    logic release_event;
    logic press_event;
    logic is_pressed;
  } result_t;

  localparam time_ms_t DebounceReset = 32'd30;
  localparam time_ms_t LongReset     = 32'd1000;
  localparam time_ms_t WindowReset   = 32'd400;

endpackage

`default_nettype wire

// ----- sv/bcc_cfg.sv -----
// ----------------------------------------------------------------------------
// bcc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [bcc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [bcc_pkg::TimeW-1:0]    cfg_wdata,
  output bcc_pkg::cfg_t                     cfg_o
);
  import bcc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE_TIME:       cfg_nxt.debounce_time       = cfg_wdata;
        REG_LONG_CLICK_TIME:     cfg_nxt.long_click_time     = cfg_wdata;
        REG_DOUBLE_CLICK_WINDOW: cfg_nxt.double_click_window = cfg_wdata;
        REG_ACTIVE_LOW:          cfg_nxt.active_low          = cfg_wdata[0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time       <= DebounceReset;
      cfg_r.long_click_time     <= LongReset;
      cfg_r.double_click_window <= WindowReset;
      cfg_r.active_low          <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// ----- sv/bcc_step.sv -----
// ----------------------------------------------------------------------------
// bcc_step
// Debounce and click state, updated once per poll word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_step (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bcc_pkg::cfg_t             cfg_i,
  input  wire logic                      step_en,
  input  wire logic                      pin_level,
  input  wire logic [bcc_pkg::TimeW-1:0] now_time,
  output bcc_pkg::result_t               result_o
);
  import bcc_pkg::*;

  logic         raw_seen_r, raw_seen_nxt;
  logic         stable_level_r, stable_level_nxt;
  time_ms_t     raw_change_time_r, raw_change_time_nxt;
  time_ms_t     press_start_time_r, press_start_time_nxt;
  time_ms_t     last_short_release_r, last_short_release_nxt;
  click_phase_t phase_r, phase_nxt;
  logic         armed_r, armed_nxt;

  logic     raw;
  time_ms_t held_ms;
  time_ms_t since_ms;
  logic     deb;
  logic     press_edge;
  logic     rel_edge;
  logic     is_short;
  logic     dbl_ok;
  logic     short_rel;
  logic     long_hit;

  assign raw          = cfg_i.active_low ? ~pin_level : pin_level;
  assign raw_seen_nxt = raw;
  // restart the hold timer on every raw change
  assign raw_change_time_nxt = (raw != raw_seen_r) ? now_time : raw_change_time_r;
  assign deb = ((now_time - raw_change_time_nxt) >= cfg_i.debounce_time) ? raw
                                                                          : stable_level_r;
  assign stable_level_nxt = deb;

  assign press_edge = (deb != stable_level_r) & deb;
  assign rel_edge   = (deb != stable_level_r) & ~deb;
  assign held_ms    = now_time - press_start_time_r;
  assign since_ms   = now_time - last_short_release_r;
  assign is_short   = held_ms < cfg_i.long_click_time;
  // a stored time of zero means no earlier short release
  assign dbl_ok     = (last_short_release_r != '0) && (since_ms <= cfg_i.double_click_window);
  assign short_rel  = rel_edge & armed_r & (phase_r != PHASE_LONGED) & is_short;
  assign long_hit   = (deb == stable_level_r) & (phase_r == PHASE_PRESSED) & armed_r &
                      ~is_short;

  // next state
  always_comb begin
    phase_nxt              = phase_r;
    armed_nxt              = armed_r;
    press_start_time_nxt   = press_start_time_r;
    last_short_release_nxt = last_short_release_r;
    if (press_edge) begin
      phase_nxt            = PHASE_PRESSED;
      press_start_time_nxt = now_time;
    end else if (rel_edge) begin
      phase_nxt = PHASE_RELEASED;
      armed_nxt = 1'b1;
      if (short_rel && !dbl_ok) begin
        last_short_release_nxt = now_time;
      end else begin
        last_short_release_nxt = '0;
      end
    end else if (long_hit) begin
      phase_nxt              = PHASE_LONGED;
      last_short_release_nxt = '0;
    end
  end

  // outputs
  always_comb begin
    result_o.is_pressed    = deb;
    result_o.press_event   = press_edge & armed_r;
    result_o.release_event = rel_edge & armed_r;
    result_o.long_event    = long_hit;
    result_o.double_event  = short_rel & dbl_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_seen_r           <= 1'b0;
      stable_level_r       <= 1'b0;
      raw_change_time_r    <= '0;
      press_start_time_r   <= '0;
      last_short_release_r <= '0;
      phase_r              <= PHASE_RELEASED;
      armed_r              <= 1'b0;
    end else if (step_en) begin
      raw_seen_r           <= raw_seen_nxt;
      stable_level_r       <= stable_level_nxt;
      raw_change_time_r    <= raw_change_time_nxt;
      press_start_time_r   <= press_start_time_nxt;
      last_short_release_r <= last_short_release_nxt;
      phase_r              <= phase_nxt;
      armed_r              <= armed_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/button_click_classifier_core.sv -----
// ----------------------------------------------------------------------------
// button_click_classifier_core
// Debounced push-button classifier: press, release, long and double click.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_*     slave      tdata: pin_level [0], now_time [32:1], zero pad
//  out_*    master     tdata: is_pressed, press, release, long, double [4:0]
//  cfg_*    write      index 0..3, data up to 32 bits
//
//  One poll word per cycle while out_tready does not stall: input register,
//  one pass of compare logic, then the state and result registers together.
//  The step is bounded by three parallel 32-bit subtract/compare paths.
//  Reset (rst_n low, synchronous) clears state and loads register defaults.
//  A stalled out_tready holds the result and backs up into in_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_click_classifier_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output wire logic                            in_tready,
  // pin_level [0], now_time [32:1], zeros [39:33]
  input  wire logic [bcc_pkg::InDataW-1:0]     in_tdata,
  output wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  // is_pressed [0], press_event [1], release_event [2], long_event [3],
  // double_event [4], zeros [7:5]
  output wire logic [bcc_pkg::OutDataW-1:0]    out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [bcc_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [bcc_pkg::TimeW-1:0]       cfg_wdata
);
  import bcc_pkg::*;

  cfg_t     cfg;
  result_t  step_res;

  logic     in_valid_r;
  logic     pin_r;
  time_ms_t now_r;
  logic     out_valid_r;
  result_t  out_res_r;

  logic out_free;
  logic advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  bcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  bcc_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .step_en   (advance),
    .pin_level (pin_r),
    .now_time  (now_r),
    .result_o  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // payload: load input word on accept, result word on advance
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pin_r <= in_tdata[0];
      now_r <= in_tdata[TimeW:1];
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_res_r};

endmodule

`default_nettype wire

// ----- sv/bcc_checker.sv -----
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks for the button click classifier, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [bcc_pkg::OutDataW-1:0] out_tdata
);
  import bcc_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_press_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0] && !out_tdata[2])
    else $error("press event without pressed level");

  a_release_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[0] && !out_tdata[3])
    else $error("release event with pressed level or long event");

  a_long_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[0] && !out_tdata[1])
    else $error("long event outside a held press");

  a_double_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[2])
    else $error("double event without release event");

endmodule

bind button_click_classifier_core bcc_checker u_bcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the debounced button click classifier.
// Sends timestamped pin polls as press gestures, double clicks, long holds,
// bounce and timestamp noise under several register settings, predicts
// every result word in the bench and compares it field by field.
// ----------------------------------------------------------------------------

module tb;
  import bcc_pkg::*;

  typedef struct packed {
    time_ms_t now;
    logic     pin;
  } poll_t;

  localparam int NumPhases    = 12;
  localparam int PhasePolls   = 145;
  localparam int LongHoldCyc  = 120;
  localparam int DurCap       = 3000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [TimeW-1:0]    cfg_wdata = '0;

  // register copies and click state of the predictor
  time_ms_t     deb_ms = DebounceReset;
  time_ms_t     long_ms = LongReset;
  time_ms_t     win_ms = WindowReset;
  logic         al = 1'b1;
  logic         raw_seen = 1'b0;
  logic         stable_lvl = 1'b0;
  time_ms_t     raw_chg_t = '0;
  time_ms_t     press_t = '0;
  time_ms_t     short_rel_t = '0;
  click_phase_t phase = PHASE_RELEASED;
  logic         armed = 1'b0;

  poll_t   poll_q[$];
  result_t click_q[$];
  int      polls_queued = 0;
  int      polls_taken = 0;
  int      words_seen = 0;
  int      errors = 0;
  bit      in_taken = 1'b0;
  bit      out_taken = 1'b0;
  bit      tx_idle = 1'b0;
  bit      rx_idle = 1'b0;
  int      tx_gap = 0;
  int      rx_hold = 0;
  time_ms_t cur_ms = '0;
  string   field_name[5] = '{"is_pressed", "press_event", "release_event",
                             "long_event", "double_event"};

  button_click_classifier_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t ns, word %0d: %s", $time, words_seen, msg);
  endtask

  task automatic classify_poll(input logic pin, input time_ms_t now, output result_t r);
    logic lvl;
    lvl = al ? ~pin : pin;
    r = '0;
    if (lvl != raw_seen) begin
      raw_seen = lvl;
      raw_chg_t = now;
    end
    lvl = stable_lvl;
    if (time_ms_t'(now - raw_chg_t) >= deb_ms) lvl = raw_seen;
    if (lvl != stable_lvl) begin
      stable_lvl = lvl;
      if (lvl) begin
        r.press_event = armed;
        phase = PHASE_PRESSED;
        press_t = now;
      end else begin
        r.release_event = armed;
        // only a short, unlonged press can open or close a double click
        if (phase != PHASE_LONGED && armed) begin
          if (time_ms_t'(now - press_t) < long_ms) begin
            if (short_rel_t != '0 && time_ms_t'(now - short_rel_t) <= win_ms) begin
              r.double_event = 1'b1;
              short_rel_t = '0;
            end else begin
              short_rel_t = now;
            end
          end else begin
            short_rel_t = '0;
          end
        end else begin
          short_rel_t = '0;
        end
        phase = PHASE_RELEASED;
        armed = 1'b1;
      end
    end else if (phase == PHASE_PRESSED && armed &&
                 time_ms_t'(now - press_t) >= long_ms) begin
      r.long_event = 1'b1;
      phase = PHASE_LONGED;
      short_rel_t = '0;
    end
    r.is_pressed = stable_lvl;
  endtask

  // sample both handshakes; predict on input words, check output words
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        classify_poll(in_tdata[0], in_tdata[TimeW:1], want);
        click_q.push_back(want);
        polls_taken++;
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        words_seen++;
        out_taken = 1'b1;
        if (click_q.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", out_tdata));
        end else begin
          want = click_q.pop_front();
          got = result_t'(out_tdata[4:0]);
          for (int b = 0; b < 5; b++) begin
            if (got[b] !== want[b]) begin
              report_mismatch($sformatf("%s got %b want %b", field_name[b], got[b],
                                        want[b]));
            end
          end
        end
      end
    end
  end

  // input driver: hold the word until taken, then wait out the drawn gap
  always @(negedge clk) begin
    poll_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      in_tvalid <= 1'b1;
    end else begin
      in_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (poll_q.size() != 0) begin
        w = poll_q.pop_front();
        in_tdata <= InDataW'(w);
        in_tvalid <= 1'b1;
        tx_gap = tx_idle ? $urandom_range(0, 7) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stall per word, two long hold-offs mid-run
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_taken) begin
      out_taken = 1'b0;
      rx_hold = rx_idle ? $urandom_range(0, 7) : 0;
      if (words_seen == 400 || words_seen == 1200) rx_hold = LongHoldCyc;
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [TimeW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE_TIME:       deb_ms = val;
      REG_LONG_CLICK_TIME:     long_ms = val;
      REG_DOUBLE_CLICK_WINDOW: win_ms = val;
      REG_ACTIVE_LOW:          al = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input time_ms_t deb, input time_ms_t lng, input time_ms_t win,
                          input logic low);
    logic [TimeW-1:0] junk;
    // active_low is one bit wide: load the upper bits with junk
    junk = $urandom();
    write_reg(REG_DEBOUNCE_TIME, deb);
    write_reg(REG_LONG_CLICK_TIME, lng);
    write_reg(REG_DOUBLE_CLICK_WINDOW, win);
    write_reg(REG_ACTIVE_LOW, {junk[TimeW-1:1], low});
  endtask

  task automatic push_poll(input logic pin, input time_ms_t t);
    poll_t p;
    p.pin = pin;
    p.now = t;
    poll_q.push_back(p);
    polls_queued++;
    cur_ms = t;
  endtask

  // wait until every word is back, then let the pipeline settle
  task automatic drain;
    while (polls_taken != polls_queued || click_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int unsigned clip(input time_ms_t v);
    return (v > DurCap) ? DurCap : int'(v);
  endfunction

  function automatic time_ms_t pick_ms(input time_ms_t typical);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      default: return typical / 2 + $urandom_range(0, typical);
    endcase
  endfunction

  task automatic hold_level(input logic pin, input int unsigned dur);
    int unsigned spent;
    int unsigned stride;
    spent = 0;
    while (spent == 0 || spent < dur) begin
      stride = $urandom_range(1, dur / 4 + 1);
      spent += stride;
      push_poll(pin, cur_ms + stride);
    end
  endtask

  // chatter around an edge, shorter than a typical debounce
  task automatic bounce(input logic pin);
    int unsigned n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      push_poll((i % 2 == 0) ? pin : ~pin, cur_ms + $urandom_range(1, 3));
    end
  endtask

  task automatic gesture;
    int unsigned deb_c;
    int unsigned long_c;
    int unsigned win_c;
    int unsigned press_ms;
    int unsigned gap_ms;
    int unsigned kind;
    int unsigned n;
    logic        down;
    deb_c = clip(deb_ms);
    long_c = clip(long_ms);
    win_c = clip(win_ms);
    down = al ? 1'b0 : 1'b1;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 2) == 0) push_poll(1'($urandom_range(0, 1)), $urandom());
        else push_poll(1'($urandom_range(0, 1)), cur_ms + $urandom_range(0, 3 * deb_c + 10));
      end
    end else begin
      if (kind < 65) press_ms = deb_c + 1 + $urandom_range(0, long_c);
      else press_ms = deb_c + long_c + $urandom_range(0, 100);
      // a quick re-press after a short click makes a double click
      if ($urandom_range(0, 1)) gap_ms = deb_c + 1 + $urandom_range(0, win_c / 2 + 1);
      else gap_ms = deb_c + 1 + $urandom_range(0, 2 * win_c + 50);
      if ($urandom_range(0, 3) == 0) bounce(down);
      hold_level(down, press_ms);
      if ($urandom_range(0, 3) == 0) bounce(~down);
      hold_level(~down, gap_ms);
    end
  endtask

  initial begin
    int start_cnt;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, pin low means pressed
    push_poll(1'b1, 32'd0);
    push_poll(1'b0, 32'd10);
    push_poll(1'b0, 32'd40);          // first press, not armed yet
    push_poll(1'b1, 32'd60);
    push_poll(1'b1, 32'd90);          // first release arms the events
    push_poll(1'b0, 32'd100);
    push_poll(1'b0, 32'd130);
    push_poll(1'b1, 32'd200);
    push_poll(1'b1, 32'd230);         // short click
    push_poll(1'b0, 32'd250);
    push_poll(1'b0, 32'd280);
    push_poll(1'b1, 32'd300);
    push_poll(1'b1, 32'd330);         // double click
    push_poll(1'b0, 32'd400);
    push_poll(1'b0, 32'd430);
    push_poll(1'b0, 32'd1429);
    push_poll(1'b0, 32'd1430);        // long click
    push_poll(1'b1, 32'd1500);
    push_poll(1'b1, 32'd1530);
    // short release exactly at timestamp zero cannot open a double click
    push_poll(1'b0, 32'hFFFF_FF00);
    push_poll(1'b0, 32'hFFFF_FF1E);
    push_poll(1'b1, 32'hFFFF_FFE2);
    push_poll(1'b1, 32'hFFFF_FFFF);
    push_poll(1'b1, 32'd0);
    push_poll(1'b0, 32'd20);
    push_poll(1'b0, 32'd50);
    push_poll(1'b1, 32'd60);
    push_poll(1'b1, 32'd90);
    drain();

    // zero debounce and zero long time, pin high means pressed
    set_regs('0, '0, '0, 1'b0);
    push_poll(1'b0, 32'd5);
    push_poll(1'b1, 32'd6);           // accepted in the same poll
    push_poll(1'b1, 32'd6);           // long at once
    push_poll(1'b0, 32'd7);
    push_poll(1'b1, 32'd8);
    push_poll(1'b0, 32'd8);           // release is never short
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == 0) set_regs('0, '0, '0, 1'b0);
      else if (ph == 1) set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      else if (ph == NumPhases - 1) set_regs(DebounceReset, LongReset, WindowReset, 1'b1);
      else set_regs(pick_ms(DebounceReset), pick_ms(LongReset), pick_ms(WindowReset),
                    1'($urandom_range(0, 1)));
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 3))
        0:       cur_ms = $urandom();
        1:       cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        default: ;
      endcase
      start_cnt = polls_queued;
      while (polls_queued - start_cnt < PhasePolls) gesture();
      drain();
    end

    repeat (10) @(negedge clk);
    if (errors == 0 && click_q.size() == 0) begin
      $display("PASS button_click_classifier_core");
    end else begin
      $display("FAIL button_click_classifier_core");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL button_click_classifier_core");
    $finish;
  end

endmodule
